// ----- hdl/rmsedf_pkg.sv -----
// ----------------------------------------------------------------------------
// Task selector package
// Shared widths, constants and types for the rate-monotonic / earliest
// deadline first task selector and its channel interfaces.
// ----------------------------------------------------------------------------
package rmsedf_pkg;

	// Field widths of a table entry and of a result.
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned KEY_W   = FIELD_W + 1;
	localparam int unsigned ID_W    = 7;

	// Entries beyond this count in one round are ignored.
	localparam int unsigned MAX_TASKS = 64;

	// Running key value that lies above any real key.
	localparam logic [KEY_W-1:0] KEY_NONE = '1;

	// Deadline value and work threshold of the schedulability check.
	localparam logic [FIELD_W-1:0] DEADLINE_TIGHT = FIELD_W'(1);
	localparam logic [FIELD_W-1:0] WORK_LIMIT     = FIELD_W'(1);

	// Selection policy held in the configuration register.
	typedef enum logic {
		POLICY_RMS = 1'b0,
		POLICY_EDF = 1'b1
	} policy_t;

	// One entry of the task table.
	typedef struct packed {
		logic [FIELD_W-1:0] task_period;
		logic [FIELD_W-1:0] deadline_timer;
		logic [FIELD_W-1:0] work_left;
		logic               done_req;
		logic               ready_req;
		logic               is_last;
	} entry_t;

endpackage

// ----- hdl/rmsedf_entry_if.sv -----
// ----------------------------------------------------------------------------
// Task table entry channel
// Valid/ready channel that carries one task table entry per request.
// ----------------------------------------------------------------------------
interface rmsedf_entry_if;
	import rmsedf_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] task_period;
	logic [FIELD_W-1:0] deadline_timer;
	logic [FIELD_W-1:0] work_left;
	logic               done_req;
	logic               ready_req;
	logic               is_last;

	modport source (
		output valid, task_period, deadline_timer, work_left, done_req, ready_req, is_last,
		input  ready
	);

	modport sink (
		input  valid, task_period, deadline_timer, work_left, done_req, ready_req, is_last,
		output ready
	);

endinterface

// ----- hdl/rmsedf_result_if.sv -----
// ----------------------------------------------------------------------------
// Selection result channel
// Valid/ready channel that carries the chosen task id and the error id.
// ----------------------------------------------------------------------------
interface rmsedf_result_if;
	import rmsedf_pkg::*;

	logic            valid;
	logic            ready;
	logic [ID_W-1:0] selected_id;
	logic [ID_W-1:0] error_id;

	modport source (
		output valid, selected_id, error_id,
		input  ready
	);

	modport sink (
		input  valid, selected_id, error_id,
		output ready
	);

endinterface

// ----- hdl/rms_edf_task_selector.sv -----
// ----------------------------------------------------------------------------
// Rate-monotonic / earliest deadline first task selector
// Scans one task table per round and reports the task to run and the
// sticky id of the first task that cannot meet its deadline.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Handshake          Contents
//  entry      in         valid/ready        one task table entry
//  result     out        valid/ready        selected_id, error_id
//  cfg        in         cfg_we, no ready   policy (0 = RMS, 1 = EDF)
//
// An entry is taken into an input register and folded into the running
// minimum in the next cycle, one entry per cycle, unless the fold stage
// stalls; the entry marked last loads the result register from the fold stage.
// The result register is one deep: while a result waits, entries keep
// flowing until the next last-marked entry reaches the fold stage.
// Reset clears the policy, the round state and the sticky error id.
// ----------------------------------------------------------------------------
module rms_edf_task_selector #(
	parameter int unsigned MAX_TASKS = rmsedf_pkg::MAX_TASKS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	rmsedf_entry_if.sink             entry,
	rmsedf_result_if.source          result
);
	import rmsedf_pkg::*;

	// Configuration and pipeline state.
	policy_t         policy_q;
	entry_t          entry_s1;
	policy_t         policy_s1;
	logic            valid_s1;

	// Round state.
	logic [ID_W-1:0]  slot_count_q;
	logic [KEY_W-1:0] best_key_q;
	logic [ID_W-1:0]  best_slot_q;
	logic [ID_W-1:0]  error_slot_q;
	logic             error_seen_q;

	// Result register.
	logic            res_valid_q;
	logic [ID_W-1:0] selected_id_q;
	logic [ID_W-1:0] error_id_q;

	// Next-state values of the fold stage.
	logic             fold_go;
	logic             in_range;
	logic [ID_W-1:0]  slot_id;
	logic             err_hit;
	logic [KEY_W-1:0] cand_key;
	logic             take;
	logic [KEY_W-1:0] best_key_d;
	logic [ID_W-1:0]  best_slot_d;
	logic [ID_W-1:0]  error_slot_d;
	logic             error_seen_d;
	logic [ID_W-1:0]  slot_count_d;

	// The fold stage stalls only when it holds a last entry and the result
	// register is still occupied.
	assign fold_go     = valid_s1 && !(entry_s1.is_last && res_valid_q && !result.ready);
	assign entry.ready = !valid_s1 || fold_go;

	// Selection and schedulability check of the entry in the fold stage.
	always_comb begin
		in_range = slot_count_q < ID_W'(MAX_TASKS);
		slot_id  = slot_count_q + ID_W'(1);
		err_hit  = in_range && !entry_s1.done_req && !error_seen_q &&
			(entry_s1.deadline_timer == DEADLINE_TIGHT) &&
			(entry_s1.work_left > WORK_LIMIT);
		if (policy_s1 == POLICY_RMS) begin
			cand_key = {1'b0, entry_s1.task_period};
			take     = cand_key < best_key_q;
		end else begin
			cand_key = {1'b0, entry_s1.deadline_timer};
			take     = cand_key <= best_key_q;
		end
		take = take && in_range && !entry_s1.done_req && entry_s1.ready_req;

		best_key_d   = take ? cand_key : best_key_q;
		best_slot_d  = take ? slot_id : best_slot_q;
		error_slot_d = err_hit ? slot_id : error_slot_q;
		error_seen_d = error_seen_q || err_hit;
		slot_count_d = in_range ? slot_id : slot_count_q;
	end

	// Policy register, input register and round state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= POLICY_RMS;
			valid_s1     <= 1'b0;
			slot_count_q <= '0;
			best_key_q   <= KEY_NONE;
			best_slot_q  <= '0;
			error_slot_q <= '0;
			error_seen_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= policy_t'(cfg_wdata);
			end
			if (entry.ready) begin
				valid_s1 <= entry.valid;
			end
			if (fold_go) begin
				error_slot_q <= error_slot_d;
				if (entry_s1.is_last) begin
					slot_count_q <= '0;
					best_key_q   <= KEY_NONE;
					best_slot_q  <= '0;
					error_seen_q <= 1'b0;
				end else begin
					slot_count_q <= slot_count_d;
					best_key_q   <= best_key_d;
					best_slot_q  <= best_slot_d;
					error_seen_q <= error_seen_d;
				end
			end
			if (fold_go && entry_s1.is_last) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the input stage and the result.
	always_ff @(posedge clk) begin
		if (entry.ready && entry.valid) begin
			entry_s1.task_period    <= entry.task_period;
			entry_s1.deadline_timer <= entry.deadline_timer;
			entry_s1.work_left      <= entry.work_left;
			entry_s1.done_req       <= entry.done_req;
			entry_s1.ready_req      <= entry.ready_req;
			entry_s1.is_last        <= entry.is_last;
			policy_s1               <= policy_q;
		end
		if (fold_go && entry_s1.is_last) begin
			selected_id_q <= best_slot_d;
			error_id_q    <= error_slot_d;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.selected_id = selected_id_q;
	assign result.error_id    = error_id_q;

endmodule
